[rtl/siphrc_pkg.sv]
// Shared types, codes and the SipRound function for the SipHash round core.
package siphrc_pkg;

    localparam int LANE_W  = 64;
    localparam int COUNT_W = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [LANE_W-1:0]  FINAL_XOR            = 64'h0000_0000_0000_00ff;
    localparam logic [COUNT_W-1:0] COMPRESS_ROUNDS_INIT = 4'd2;
    localparam logic [COUNT_W-1:0] FINAL_ROUNDS_INIT    = 4'd4;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_ABSORB = 2'd1,
        OP_FINAL  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_LANE0      = 3'd0,
        CFG_INIT_LANE1      = 3'd1,
        CFG_INIT_LANE2      = 3'd2,
        CFG_INIT_LANE3      = 3'd3,
        CFG_COMPRESS_ROUNDS = 3'd4,
        CFG_FINAL_ROUNDS    = 3'd5
    } cfg_idx_t;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_ROUND = 1'b1
    } state_t;

    typedef struct packed {
        logic [LANE_W-1:0] a;
        logic [LANE_W-1:0] b;
        logic [LANE_W-1:0] c;
        logic [LANE_W-1:0] d;
    } lanes_t;

    typedef struct packed {
        logic load_start;
        logic load_work;
        logic do_round;
        logic commit;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  in_op;
        logic rounds_zero;
        logic work_final;
        logic out_busy;
    } ctrl_stat_t;

    function automatic logic [LANE_W-1:0] rotl(input logic [LANE_W-1:0] x,
                                               input int unsigned n);
        rotl = (x << n) | (x >> (LANE_W - n));
    endfunction

    // One full SipRound: two add/rotate/xor half steps.
    function automatic lanes_t sip_round(input lanes_t s);
        lanes_t r;
        r = s;
        r.a = r.a + r.b;
        r.c = r.c + r.d;
        r.b = rotl(r.b, 13);
        r.d = rotl(r.d, 16);
        r.b = r.b ^ r.a;
        r.d = r.d ^ r.c;
        r.a = rotl(r.a, 32);
        r.c = r.c + r.b;
        r.a = r.a + r.d;
        r.b = rotl(r.b, 17);
        r.d = rotl(r.d, 21);
        r.b = r.b ^ r.c;
        r.d = r.d ^ r.a;
        r.c = rotl(r.c, 32);
        sip_round = r;
    endfunction

endpackage

[rtl/siphrc_ctrl.sv]
// Controller state machine: sequences load, rounds and commit/emit per request.
module siphrc_ctrl
    import siphrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    case (stat.in_op)
                        OP_START:
                        begin
                            cmd.load_start = 1'b1;
                        end
                        OP_ABSORB, OP_FINAL:
                        begin
                            cmd.load_work = 1'b1;
                            state_next    = ST_ROUND;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ROUND:
            begin
                if (!stat.rounds_zero)
                begin
                    cmd.do_round = 1'b1;
                end
                else if (stat.work_final)
                begin
                    // hold the digest until the output register frees up
                    if (!stat.out_busy)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/siphrc_datapath.sv]
// Datapath: config registers, stored lanes, working lanes, round counter, digest register.
module siphrc_datapath
    import siphrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            opcode,
    input  logic [LANE_W-1:0]     message_word,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [LANE_W-1:0]     cfg_data,
    input  ctrl_cmd_t             cmd,
    output ctrl_stat_t            stat,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LANE_W-1:0]     digest
);

    lanes_t               init_reg;
    logic [COUNT_W-1:0]   compress_rounds_reg;
    logic [COUNT_W-1:0]   final_rounds_reg;

    lanes_t               lanes_reg;
    lanes_t               work_reg;
    lanes_t               work_next;
    lanes_t               start_work;
    logic [LANE_W-1:0]    msg_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 work_final_reg;
    logic                 out_valid_reg;
    logic [LANE_W-1:0]    digest_reg;
    op_t                  in_op;

    assign in_op = op_t'(opcode);

    // lane2 is xored with 0xff on finalize, lane3 with the word on absorb
    always_comb
    begin
        start_work = lanes_reg;
        if (in_op == OP_FINAL)
        begin
            start_work.c = lanes_reg.c ^ FINAL_XOR;
        end
        else
        begin
            start_work.d = lanes_reg.d ^ message_word;
        end
    end

    assign work_next = sip_round(work_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg            <= '0;
            compress_rounds_reg <= COMPRESS_ROUNDS_INIT;
            final_rounds_reg    <= FINAL_ROUNDS_INIT;
        end
        else if (cfg_write_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_INIT_LANE0:      init_reg.a          <= cfg_data;
                CFG_INIT_LANE1:      init_reg.b          <= cfg_data;
                CFG_INIT_LANE2:      init_reg.c          <= cfg_data;
                CFG_INIT_LANE3:      init_reg.d          <= cfg_data;
                CFG_COMPRESS_ROUNDS: compress_rounds_reg <= cfg_data[COUNT_W-1:0];
                CFG_FINAL_ROUNDS:    final_rounds_reg    <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_reg      <= '0;
            count_reg      <= '0;
            work_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_start)
            begin
                lanes_reg <= init_reg;
            end
            else if (cmd.commit)
            begin
                lanes_reg <= {work_reg.a ^ msg_reg, work_reg.b, work_reg.c, work_reg.d};
            end

            if (cmd.load_work)
            begin
                count_reg      <= (in_op == OP_FINAL) ? final_rounds_reg : compress_rounds_reg;
                work_final_reg <= (in_op == OP_FINAL);
            end
            else if (cmd.do_round)
            begin
                count_reg <= count_reg - 1'b1;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            work_reg <= start_work;
            msg_reg  <= message_word;
        end
        else if (cmd.do_round)
        begin
            work_reg <= work_next;
        end

        if (cmd.emit)
        begin
            digest_reg <= work_reg.a ^ work_reg.b ^ work_reg.c ^ work_reg.d;
        end
    end

    assign stat.in_op       = in_op;
    assign stat.rounds_zero = (count_reg == '0);
    assign stat.work_final  = work_final_reg;
    assign stat.out_busy    = out_valid_reg & out_stall;

    assign out_valid = out_valid_reg;
    assign digest    = digest_reg;

endmodule

[rtl/siphash_round_core.sv]
// SipHash round core top level: controller plus datapath.
//
// Input channel (in_valid/in_stall) carries one request: opcode and message_word.
//   start    loads the four lanes from init_lane0..3 in the accepting cycle.
//   absorb   xors the word into lane3, runs compress_rounds SipRounds, xors it into lane0.
//   finalize xors 0xff into lane2 on a working copy, runs final_rounds SipRounds and
//            sends the xor of the four lanes on the output channel; stored lanes are kept.
//   opcode 3 is dropped.
// One SipRound per clock through a single round unit, one request at a time.
// start and opcode 3 complete in the accepting cycle; absorb and finalize step through
// load, the SipRounds in turn, then commit or emit.
// The digest appears in out_valid/digest the cycle after the emit step and sits in
// an output register; while out_stall holds it, further start/absorb requests are
// still taken, and a following finalize waits at its emit step.
// Write configuration (cfg_write_en, cfg_index, cfg_data) only while idle; not enforced.
// Reset clears lanes and init values, sets compress_rounds to 2, final_rounds to 4.
module siphash_round_core
    import siphrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic [LANE_W-1:0]    message_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [LANE_W-1:0]    digest,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LANE_W-1:0]    cfg_data
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    siphrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    siphrc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .opcode       (opcode),
        .message_word (message_word),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest       (digest)
    );

endmodule
